// ===== src/axis_twist_deformer_assert.svh =====
// Assertion macros shared by the twist deformer RTL.
`ifndef AXIS_TWIST_DEFORMER_ASSERT_SVH
`define AXIS_TWIST_DEFORMER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define ATD_ASSERT_IMP(lbl, pre, post, msg) lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define ATD_ASSERT_NXT(lbl, pre, post, msg) lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

// ===== src/atd_pkg.sv =====
// Shared constants and tables for the twist deformer.
`timescale 1ns / 1ps
package atd_pkg;

  localparam int unsigned MAX_POINTS   = 64;
  localparam int unsigned CORDIC_STEPS = 31;
  localparam int unsigned MOD_STEPS    = 14;

  // Angles in Q.30
  localparam logic [47:0]        TWO_PI_Q30  = 48'd6746518852;
  localparam logic signed [35:0] TWO_PI_S    = 36'sd6746518852;
  localparam logic signed [35:0] PI_S        = 36'sd3373259426;
  localparam logic signed [35:0] HALF_PI_S   = 36'sd1686629713;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  // Register indexes
  localparam logic CFG_AXIS  = 1'b0;
  localparam logic CFG_ANGLE = 1'b1;

  // Axis codes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // Arctangent table, Q.30
  function automatic logic signed [35:0] atan_q30(input logic [4:0] i);
    logic signed [35:0] r;
    case (i)
      5'd0:  r = 36'sh03243F6A8;
      5'd1:  r = 36'sh01DAC6705;
      5'd2:  r = 36'sh00FADBAFC;
      5'd3:  r = 36'sh007F56EA6;
      5'd4:  r = 36'sh003FEAB76;
      5'd5:  r = 36'sh001FFD55B;
      5'd6:  r = 36'sh000FFFAAA;
      5'd7:  r = 36'sh0007FFF55;
      5'd8:  r = 36'sh0003FFFEA;
      5'd9:  r = 36'sh0001FFFFD;
      5'd10: r = 36'sh0000FFFFF;
      5'd11: r = 36'sh00007FFFF;
      5'd12: r = 36'sh00003FFFF;
      5'd13: r = 36'sh00001FFFF;
      5'd14: r = 36'sh00000FFFF;
      5'd15: r = 36'sh000007FFF;
      5'd16: r = 36'sh000003FFF;
      5'd17: r = 36'sh000001FFF;
      5'd18: r = 36'sh000000FFF;
      5'd19: r = 36'sh0000007FF;
      5'd20: r = 36'sh0000003FF;
      5'd21: r = 36'sh0000001FF;
      5'd22: r = 36'sh0000000FF;
      5'd23: r = 36'sh00000007F;
      5'd24: r = 36'sh00000003F;
      5'd25: r = 36'sh00000001F;
      5'd26: r = 36'sh00000000F;
      5'd27: r = 36'sh000000008;
      5'd28: r = 36'sh000000004;
      5'd29: r = 36'sh000000002;
      5'd30: r = 36'sh000000001;
      default: r = 36'sh000000000;
    endcase
    return r;
  endfunction

  // Axis code three acts as Z
  function automatic logic [1:0] eff_axis(input logic [1:0] a);
    return (a == 2'd3) ? AXIS_Z : a;
  endfunction

endpackage

// ===== src/atd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module atd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== src/atd_cordic.sv =====
// Iterative angle reduction and CORDIC sine/cosine unit, Q.30.
`timescale 1ns / 1ps
module atd_cordic (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [47:0] theta_i,
  output logic               done_o,
  output logic signed [33:0] cos_o,
  output logic signed [33:0] sin_o
);

  typedef enum logic [3:0] {
    C_IDLE = 4'b0001,
    C_MOD  = 4'b0010,
    C_FOLD = 4'b0100,
    C_ITER = 4'b1000
  } cor_state_e;

  cor_state_e         state_q;
  logic [47:0]        rem_q;
  logic               tneg_q;
  logic [4:0]         step_q;
  logic signed [33:0] x_q, y_q;
  logic signed [35:0] z_q;
  logic               neg_q;
  logic               done_q;

  logic [47:0]        k_shift;
  logic signed [35:0] r0, r1, r2;
  logic               fneg;
  logic signed [33:0] dx, dy;

  assign k_shift = atd_pkg::TWO_PI_Q30 << step_q[3:0];
  assign dx = x_q >>> step_q;
  assign dy = y_q >>> step_q;

  // Fold the reduced angle into [-pi/2, pi/2]
  always_comb begin
    r0 = $signed({2'b00, rem_q[33:0]});
    if (tneg_q) begin
      r0 = -r0;
    end
    r1 = r0;
    if (r1 > atd_pkg::PI_S) begin
      r1 = r1 - atd_pkg::TWO_PI_S;
    end else if (r1 < -atd_pkg::PI_S) begin
      r1 = r1 + atd_pkg::TWO_PI_S;
    end
    r2   = r1;
    fneg = 1'b0;
    if (r1 > atd_pkg::HALF_PI_S) begin
      r2   = r1 - atd_pkg::PI_S;
      fneg = 1'b1;
    end else if (r1 < -atd_pkg::HALF_PI_S) begin
      r2   = r1 + atd_pkg::PI_S;
      fneg = 1'b1;
    end
  end

  // Sequence reduction, fold and rotation steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      done_q  <= 1'b0;
      step_q  <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        C_IDLE: begin
          if (start_i) begin
            rem_q   <= theta_i[47] ? 48'(-theta_i) : theta_i;
            tneg_q  <= theta_i[47];
            step_q  <= 5'(atd_pkg::MOD_STEPS - 1);
            state_q <= C_MOD;
          end
        end
        C_MOD: begin
          if (rem_q >= k_shift) begin
            rem_q <= rem_q - k_shift;
          end
          if (step_q == 5'd0) begin
            state_q <= C_FOLD;
          end else begin
            step_q <= step_q - 5'd1;
          end
        end
        C_FOLD: begin
          x_q     <= atd_pkg::CORDIC_GAIN;
          y_q     <= '0;
          z_q     <= r2;
          neg_q   <= fneg;
          step_q  <= '0;
          state_q <= C_ITER;
        end
        C_ITER: begin
          if (!z_q[35]) begin
            x_q <= x_q - dy;
            y_q <= y_q + dx;
            z_q <= z_q - atd_pkg::atan_q30(step_q);
          end else begin
            x_q <= x_q + dy;
            y_q <= y_q - dx;
            z_q <= z_q + atd_pkg::atan_q30(step_q);
          end
          if (step_q == 5'(atd_pkg::CORDIC_STEPS - 1)) begin
            done_q  <= 1'b1;
            state_q <= C_IDLE;
          end else begin
            step_q <= step_q + 5'd1;
          end
        end
        default: state_q <= C_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign cos_o  = neg_q ? -x_q : x_q;
  assign sin_o  = neg_q ? -y_q : y_q;

endmodule

// ===== src/axis_twist_deformer.sv =====
// Axis twist deformer: point store, extent tracking and per-point twist datapath.
// Loading takes one item per cycle while in the load phase; the set is held in a
// one-port-write RAM. On the last item every stored point is emitted, one at a
// time: a 16-step divider (skipped when its axis magnitude reaches the extent),
// 14-step angle reduction, 31-step CORDIC and shared multipliers, then the output,
// which may stall. With a zero extent a point only passes RAM read, capture, output.
// Reset (asynchronous, active low) clears count, extent and control; RAM is not cleared.
`timescale 1ns / 1ps
`include "axis_twist_deformer_assert.svh"
module axis_twist_deformer #(
  parameter int unsigned MAX_POINTS = atd_pkg::MAX_POINTS
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [0:0]   cfg_idx_i,
  input  logic [31:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // point_x, point_y, point_z, weight, zero pad (lowest bit up)
  input  logic [119:0] s_axis_tdata,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_x, out_y, out_z (lowest bit up)
  output logic [95:0]  m_axis_tdata,
  output logic         m_axis_tlast
);

  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned RW = 113;

  typedef enum logic [8:0] {
    S_LOAD  = 9'b000000001,
    S_READ  = 9'b000000010,
    S_CAP   = 9'b000000100,
    S_DIV   = 9'b000001000,
    S_MUL   = 9'b000010000,
    S_TRIG  = 9'b000100000,
    S_ROT   = 9'b001000000,
    S_BLEND = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_e;

  state_e             state_q;
  logic [1:0]         axis_q;
  logic signed [31:0] angle_q;
  logic [CW-1:0]      cnt_q, k_q;
  logic [31:0]        ext_q;

  logic signed [31:0] p_q [3];
  logic signed [34:0] rot_q [3];
  logic signed [31:0] res_q [3];
  logic [16:0]        w_q;
  logic [1:0]         ax_q, au_q, av_q;
  logic [32:0]        rem_q;
  logic [15:0]        qt_q;
  logic [3:0]         dcnt_q;
  logic               csign_q;
  logic signed [17:0] f_q;
  logic signed [49:0] prod_q;
  logic               tstart_q;
  logic signed [33:0] cs_q, sn_q;
  logic [2:0]         rstep_q;
  logic [1:0]         bstep_q;
  logic signed [65:0] mprod_q, accu_q, accv_q;
  logic signed [53:0] bprod_q;

  // Input side
  logic               load_acc, room;
  logic signed [31:0] in_c;
  logic [31:0]        in_mag;
  logic [1:0]         in_ax;

  assign s_axis_tready = (state_q == S_LOAD);
  assign load_acc      = s_axis_tvalid && s_axis_tready;
  assign room          = (cnt_q < CW'(MAX_POINTS));
  assign in_ax         = atd_pkg::eff_axis(axis_q);

  always_comb begin
    case (in_ax)
      atd_pkg::AXIS_X: in_c = $signed(s_axis_tdata[31:0]);
      atd_pkg::AXIS_Y: in_c = $signed(s_axis_tdata[63:32]);
      default:         in_c = $signed(s_axis_tdata[95:64]);
    endcase
    in_mag = in_c[31] ? (~in_c + 32'd1) : in_c;
  end

  // Point store
  logic [RW-1:0] ram_rdata;

  atd_ram #(.WIDTH(RW), .DEPTH(MAX_POINTS)) u_store (
    .clk_i   (clk_i),
    .we_i    (load_acc && room),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (s_axis_tdata[RW-1:0]),
    .re_i    (state_q == S_READ),
    .raddr_i (k_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Captured point
  logic signed [31:0] rd_p [3];
  logic [16:0]        rd_w;
  logic [1:0]         e_ax;
  logic signed [31:0] rd_c;
  logic [31:0]        rd_mag;

  always_comb begin
    rd_p[0] = $signed(ram_rdata[31:0]);
    rd_p[1] = $signed(ram_rdata[63:32]);
    rd_p[2] = $signed(ram_rdata[95:64]);
    rd_w    = ram_rdata[112:96];
    e_ax    = atd_pkg::eff_axis(axis_q);
    rd_c    = rd_p[e_ax];
    rd_mag  = rd_c[31] ? (~rd_c + 32'd1) : rd_c;
  end

  // Divider step
  logic [32:0] d_r2;
  logic        d_ge;
  logic [15:0] d_qt;

  assign d_r2 = {rem_q[31:0], 1'b0};
  assign d_ge = (d_r2 >= {1'b0, ext_q});
  assign d_qt = {qt_q[14:0], d_ge};

  // Sine and cosine
  logic signed [47:0] theta;
  logic               cor_done;
  logic signed [33:0] cor_cos, cor_sin;
  logic signed [49:0] theta_full;

  assign theta_full = prod_q + 50'sd2;
  assign theta      = 48'(theta_full >>> 2);

  atd_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (tstart_q),
    .theta_i (theta),
    .done_o  (cor_done),
    .cos_o   (cor_cos),
    .sin_o   (cor_sin)
  );

  // Rotation multiplier operands
  logic signed [31:0] m_a;
  logic signed [33:0] m_b;
  logic signed [65:0] rnd_u, rnd_v;

  always_comb begin
    case (rstep_q)
      3'd0:    begin m_a = p_q[au_q]; m_b = cs_q; end
      3'd1:    begin m_a = p_q[av_q]; m_b = sn_q; end
      3'd2:    begin m_a = p_q[au_q]; m_b = sn_q; end
      default: begin m_a = p_q[av_q]; m_b = cs_q; end
    endcase
    rnd_u = (accu_q + 66'sd536870912) >>> 30;
    rnd_v = (accv_q + 66'sd536870912) >>> 30;
  end

  // Blend operands and saturation
  logic signed [35:0] b_diff;
  logic signed [53:0] b_rnd;
  logic signed [38:0] b_sum;
  logic signed [31:0] b_sat;
  logic [1:0]         b_prev;

  always_comb begin
    b_diff = 36'(rot_q[bstep_q]) - 36'(p_q[bstep_q]);
    b_prev = bstep_q - 2'd1;
    b_rnd  = (bprod_q + 54'sd32768) >>> 16;
    b_sum  = 39'(b_rnd) + 39'(p_q[b_prev]);
    if (b_sum > 39'sd2147483647) begin
      b_sat = 32'sh7FFFFFFF;
    end else if (b_sum < -39'sd2147483648) begin
      b_sat = 32'sh80000000;
    end else begin
      b_sat = b_sum[31:0];
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q  <= atd_pkg::AXIS_Z;
      angle_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        atd_pkg::CFG_AXIS:  axis_q  <= cfg_wdata_i[1:0];
        atd_pkg::CFG_ANGLE: angle_q <= $signed(cfg_wdata_i);
        default:            ;
      endcase
    end
  end

  // Control and datapath sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_LOAD;
      cnt_q    <= '0;
      k_q      <= '0;
      ext_q    <= '0;
      tstart_q <= 1'b0;
      rstep_q  <= '0;
      bstep_q  <= '0;
      dcnt_q   <= '0;
    end else begin
      tstart_q <= 1'b0;
      case (state_q)
        S_LOAD: begin
          if (load_acc) begin
            if (room) begin
              cnt_q <= cnt_q + CW'(1);
              if (in_mag > ext_q) begin
                ext_q <= in_mag;
              end
            end
            if (s_axis_tlast) begin
              k_q     <= '0;
              state_q <= S_READ;
            end
          end
        end
        S_READ: state_q <= S_CAP;
        S_CAP: begin
          p_q     <= rd_p;
          w_q     <= (rd_w > 17'd65536) ? 17'd65536 : rd_w;
          ax_q    <= e_ax;
          au_q    <= (e_ax == atd_pkg::AXIS_X) ? atd_pkg::AXIS_Y :
                     (e_ax == atd_pkg::AXIS_Y) ? atd_pkg::AXIS_Z : atd_pkg::AXIS_X;
          av_q    <= (e_ax == atd_pkg::AXIS_X) ? atd_pkg::AXIS_Z :
                     (e_ax == atd_pkg::AXIS_Y) ? atd_pkg::AXIS_X : atd_pkg::AXIS_Y;
          csign_q <= rd_c[31];
          if (ext_q == 32'd0) begin
            res_q   <= rd_p;
            state_q <= S_OUT;
          end else if (rd_mag >= ext_q) begin
            f_q     <= rd_c[31] ? -18'sd65536 : 18'sd65536;
            state_q <= S_MUL;
          end else begin
            rem_q   <= {1'b0, rd_mag};
            qt_q    <= '0;
            dcnt_q  <= '0;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          rem_q  <= d_ge ? (d_r2 - {1'b0, ext_q}) : d_r2;
          qt_q   <= d_qt;
          dcnt_q <= dcnt_q + 4'd1;
          if (dcnt_q == 4'd15) begin
            f_q     <= csign_q ? -$signed({2'b00, d_qt}) : $signed({2'b00, d_qt});
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          prod_q   <= angle_q * f_q;
          tstart_q <= 1'b1;
          state_q  <= S_TRIG;
        end
        S_TRIG: begin
          if (cor_done) begin
            cs_q    <= cor_cos;
            sn_q    <= cor_sin;
            rstep_q <= '0;
            state_q <= S_ROT;
          end
        end
        S_ROT: begin
          mprod_q <= m_a * m_b;
          case (rstep_q)
            3'd1:    accu_q <= mprod_q;
            3'd2:    accu_q <= accu_q - mprod_q;
            3'd3:    accv_q <= mprod_q;
            3'd4:    accv_q <= accv_q + mprod_q;
            default: ;
          endcase
          if (rstep_q == 3'd5) begin
            rot_q[au_q] <= rnd_u[34:0];
            rot_q[av_q] <= rnd_v[34:0];
            rot_q[ax_q] <= 35'(p_q[ax_q]);
            bstep_q     <= '0;
            state_q     <= S_BLEND;
          end else begin
            rstep_q <= rstep_q + 3'd1;
          end
        end
        S_BLEND: begin
          if (bstep_q != 2'd3) begin
            bprod_q <= b_diff * $signed({1'b0, w_q});
          end
          if (bstep_q != 2'd0) begin
            res_q[b_prev] <= b_sat;
          end
          if (bstep_q == 2'd3) begin
            state_q <= S_OUT;
          end else begin
            bstep_q <= bstep_q + 2'd1;
          end
        end
        S_OUT: begin
          if (m_axis_tready) begin
            if (m_axis_tlast) begin
              cnt_q   <= '0;
              ext_q   <= '0;
              state_q <= S_LOAD;
            end else begin
              k_q     <= k_q + CW'(1);
              state_q <= S_READ;
            end
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  // Output item
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata  = {res_q[2], res_q[1], res_q[0]};
  assign m_axis_tlast  = ((k_q + CW'(1)) == cnt_q);

  `ATD_ASSERT_IMP(a_no_overlap, s_axis_tready, !m_axis_tvalid, "input open during emission")
  `ATD_ASSERT_IMP(a_cnt_range, 1'b1, cnt_q <= CW'(MAX_POINTS), "point count beyond capacity")
  `ATD_ASSERT_NXT(a_back_to_load, m_axis_tvalid && m_axis_tready && m_axis_tlast, s_axis_tready && cnt_q == '0, "no return to load after last item")
  `ATD_ASSERT_IMP(a_cordic_start, tstart_q, state_q == S_TRIG, "CORDIC started outside trig phase")

endmodule
